// ----- sv/assert_macros.svh -----
// assertion macros shared by the line parser modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- sv/blrp_pkg.sv -----
// types and constants of the interval-file line parser
// no dependencies; imported by blrp_num, bed_line_record_parser and the bench files
package blrp_pkg;

	// number scan phases
	localparam logic [1:0] PH_SKIP  = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] VAL_NONE  = 32'hFFFF_FFFF;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_R     = 8'h72;

	localparam logic [1:0] FIELD_MAX = 2'd3;
	localparam logic [7:0] NAME_MAX  = 8'd255;
	localparam logic [7:0] PREFIX_LEN = 8'd3;
	localparam logic [7:0] LIMIT_RESET = 8'd40;

	// control from the field tracker to the number scanner
	typedef struct packed {
		logic clear;
		logic feed;
	} num_ctl_t;

endpackage

// ----- sv/blrp_num.sv -----
// decimal number scanner with atol-style skip, sign and 32-bit saturation
// depends on blrp_pkg and assert_macros.svh
`include "assert_macros.svh"
module blrp_num
	import blrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  num_ctl_t    ctl,
	input  logic [7:0]  text_byte,
	output logic [31:0] value
);

	logic [1:0]  phase_q;
	logic        neg_q;
	logic [31:0] mag_q;

	logic        is_digit;
	logic        is_space;
	logic [35:0] mag_x10;
	logic [35:0] mag_next;

	assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign is_space = (text_byte == CH_SPACE) || (text_byte inside {[CH_TAB:CH_CR]});
	assign mag_x10  = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0};
	assign mag_next = mag_x10 + {32'd0, text_byte[3:0] - CH_ZERO[3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			neg_q   <= 1'b0;
			mag_q   <= '0;
		end else if (ctl.clear) begin
			phase_q <= PH_SKIP;
			neg_q   <= 1'b0;
			mag_q   <= '0;
		end else if (ctl.feed && phase_q != PH_DONE) begin
			if (is_digit) begin
				mag_q   <= (mag_next > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mag_next[31:0];
				phase_q <= PH_DIGIT;
			end else if (phase_q == PH_SKIP && is_space) begin
				phase_q <= PH_SKIP;
			end else if (phase_q == PH_SKIP && (text_byte == CH_PLUS || text_byte == CH_MINUS)) begin
				neg_q   <= (text_byte == CH_MINUS);
				phase_q <= PH_SIGN;
			end else begin
				phase_q <= PH_DONE;
			end
		end
	end

	// signed value of the digits so far
	assign value = neg_q ? (32'd0 - mag_q) : ((mag_q >= MAG_LIMIT) ? VAL_MAX : mag_q);

	`ASSERT_NEVER(a_mag_bound, clk, arst_n, mag_q > MAG_LIMIT)
	`ASSERT_CLK(a_done_sticky, clk, arst_n, (phase_q == PH_DONE && !ctl.clear) |=> phase_q == PH_DONE)
	`ASSERT_CLK(a_no_digits_no_mag, clk, arst_n, (phase_q == PH_SKIP || phase_q == PH_SIGN) |-> mag_q == 32'd0)

endmodule

// ----- sv/bed_line_record_parser.sv -----
// interval-file line parser: one text byte per beat, one record result per line
// depends on blrp_pkg, blrp_num and assert_macros.svh
//
// channel   dir  tdata                          tuser       tlast
// s_axis    in   [7:0] text_byte                -           line_end
// m_axis    out  [31:0] start_position,         [0] accepted -
//                [63:32] end_position,
//                [71:64] name_length
// cfg       in   [7:0] name_length_limit (write enable, no index)
//
// one byte beat per cycle while the output register is free or being emptied; the field
// logic works on the beat while it sits in the input register, and a beat leaves it under
// the same condition; a line-end beat loads the output register as it leaves the input register
// s_axis_tready drops only while the input register is full and the output
// register holds a result that is not taken
// reset (arst_n low) clears line state, empties both registers and sets the limit to 40
`include "assert_macros.svh"
module bed_line_record_parser
	import blrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // line_end
	// record results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [31:0] start_position, [63:32] end_position,
	                                    // [71:64] name_length
	output logic [0:0]  m_axis_tuser,   // [0] accepted
	// name length limit register
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	// config register
	logic [7:0] limit_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// line state
	logic [1:0]  field_q;
	logic [7:0]  name_len_q;
	logic        prefix_q;
	logic [31:0] start_q;
	logic [31:0] end_q;

	// output register
	logic        out_valid_q;
	logic        out_acc_q;
	logic [31:0] out_start_q;
	logic [31:0] out_end_q;
	logic [7:0]  out_name_q;

	logic        advance;
	logic        fire;
	logic        is_end;
	logic        is_tab;
	logic [1:0]  field_inc;
	logic [31:0] num_value;
	logic [31:0] start_cl;
	logic [31:0] end_cl;
	logic        prefix_next;
	logic        rec_ok;
	num_ctl_t    num_ctl;

	// stage 1 moves on when the output register is free or being emptied
	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload of the input register needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// a nul byte ends the line just like the line-end flag
	assign is_end    = last_s1 || (byte_s1 == CH_NUL);
	assign is_tab    = !is_end && (byte_s1 == CH_TAB);
	assign field_inc = (field_q == FIELD_MAX) ? FIELD_MAX : field_q + 2'd1;

	// values as they stand once the current field is closed
	assign start_cl = (field_q == 2'd1) ? num_value : start_q;
	assign end_cl   = (field_q == 2'd2) ? num_value : end_q;

	// "chr" prefix check over the first three name bytes
	always_comb begin
		prefix_next = prefix_q;
		case (name_len_q)
			8'd0:    if (byte_s1 != CH_C) prefix_next = 1'b0;
			8'd1:    if (byte_s1 != CH_H) prefix_next = 1'b0;
			8'd2:    if (byte_s1 != CH_R) prefix_next = 1'b0;
			default: prefix_next = prefix_q;
		endcase
	end

	// record test: at least three fields, chr name of legal length, end above zero
	assign rec_ok = (field_inc == FIELD_MAX) && prefix_q && (name_len_q >= PREFIX_LEN)
		&& (name_len_q < limit_q) && (end_cl != 32'd0) && !end_cl[31];

	// number scanner is fed bytes of fields 1 and 2, cleared at every field close
	assign num_ctl.clear = fire && (is_end || is_tab);
	assign num_ctl.feed  = fire && !is_end && !is_tab && (field_q == 2'd1 || field_q == 2'd2);

	blrp_num u_num (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (num_ctl),
		.text_byte (byte_s1),
		.value     (num_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q    <= 2'd0;
			name_len_q <= 8'd0;
			prefix_q   <= 1'b1;
			start_q    <= VAL_NONE;
			end_q      <= VAL_NONE;
		end else if (fire) begin
			if (is_end) begin
				// fresh line
				field_q    <= 2'd0;
				name_len_q <= 8'd0;
				prefix_q   <= 1'b1;
				start_q    <= VAL_NONE;
				end_q      <= VAL_NONE;
			end else if (is_tab) begin
				start_q <= start_cl;
				end_q   <= end_cl;
				field_q <= field_inc;
			end else if (field_q == 2'd0) begin
				prefix_q <= prefix_next;
				if (name_len_q != NAME_MAX) begin
					name_len_q <= name_len_q + 8'd1;
				end
			end
		end
	end

	// output register: loads on a line-end beat, empties when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_end) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_end) begin
			out_acc_q   <= rec_ok;
			out_start_q <= start_cl;
			out_end_q   <= end_cl;
			out_name_q  <= name_len_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_name_q, out_end_q, out_start_q};
	assign m_axis_tuser  = out_acc_q;

	`ASSERT_CLK(a_ready_when_empty, clk, arst_n, !valid_s1 |-> s_axis_tready)
	`ASSERT_CLK(a_result_from_end, clk, arst_n, $rose(m_axis_tvalid) |-> $past(valid_s1 && is_end))
	`ASSERT_CLK(a_accept_sane, clk, arst_n, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[71:64] >= PREFIX_LEN && !m_axis_tdata[63] && m_axis_tdata[63:32] != 32'd0))

endmodule

// ----- sim/bed_line_record_checker.sv -----
`timescale 1ns / 100ps
// record checker for the interval-file line parser: predicts one result per line end
// watches the byte, record and limit channels; depends on blrp_pkg
module bed_line_record_checker
	import blrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // line_end
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,   // [31:0] start_position, [63:32] end_position,
	                                    // [71:64] name_length
	input  logic [0:0]  m_axis_tuser,   // [0] accepted
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	output int          fail_count,
	output int          outstanding
);

	typedef struct packed {
		logic        accepted;
		logic [31:0] start_pos;
		logic [31:0] end_pos;
		logic [7:0]  name_len;
	} bed_record_t;

	bed_record_t expected_records[$];
	bed_record_t want;

	// line state of the predicted parser
	logic [7:0]  length_limit;
	logic [1:0]  field_idx;
	logic [7:0]  name_len;
	logic        prefix_ok;
	logic [1:0]  scan_phase;
	logic        scan_neg;
	logic [31:0] scan_mag;
	logic [31:0] start_val;
	logic [31:0] end_val;
	int          mismatches;

	task automatic report(input string msg);
		$display("%0t ns record mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic clear_line();
		field_idx  = 2'd0;
		name_len   = 8'd0;
		prefix_ok  = 1'b1;
		scan_phase = PH_SKIP;
		scan_neg   = 1'b0;
		scan_mag   = 32'd0;
		start_val  = VAL_NONE;
		end_val    = VAL_NONE;
	endtask

	// store the number of the field just ended and move on
	task automatic close_field();
		logic [31:0] value;
		if (scan_neg) begin
			value = 32'd0 - scan_mag;
		end else begin
			value = (scan_mag >= MAG_LIMIT) ? VAL_MAX : scan_mag;
		end
		if (field_idx == 2'd1) begin
			start_val = value;
		end else if (field_idx == 2'd2) begin
			end_val = value;
		end
		if (field_idx != FIELD_MAX) begin
			field_idx++;
		end
		scan_phase = PH_SKIP;
		scan_neg   = 1'b0;
		scan_mag   = 32'd0;
	endtask

	task automatic take_text_byte(input logic [7:0] b, input logic last);
		bed_record_t rec;
		logic [63:0] acc;
		logic        is_space;
		is_space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
		if (last || b == CH_NUL) begin
			close_field();
			rec.accepted  = field_idx == FIELD_MAX && prefix_ok && name_len >= PREFIX_LEN
				&& name_len < length_limit && end_val != 32'd0 && !end_val[31];
			rec.start_pos = start_val;
			rec.end_pos   = end_val;
			rec.name_len  = name_len;
			expected_records.push_back(rec);
			clear_line();
		end else if (b == CH_TAB) begin
			close_field();
		end else if (field_idx == 2'd0) begin
			if ((name_len == 8'd0 && b != CH_C) || (name_len == 8'd1 && b != CH_H)
				|| (name_len == 8'd2 && b != CH_R)) begin
				prefix_ok = 1'b0;
			end
			if (name_len != NAME_MAX) begin
				name_len++;
			end
		end else if (field_idx != FIELD_MAX && scan_phase != PH_DONE) begin
			if (b >= CH_ZERO && b <= CH_NINE) begin
				acc = 64'(scan_mag) * 64'd10 + 64'(b - CH_ZERO);
				scan_mag = (acc > 64'(MAG_LIMIT)) ? MAG_LIMIT : acc[31:0];
				scan_phase = PH_DIGIT;
			end else if (scan_phase == PH_SKIP && (b == CH_PLUS || b == CH_MINUS)) begin
				scan_neg   = (b == CH_MINUS);
				scan_phase = PH_SIGN;
			end else if (!(scan_phase == PH_SKIP && is_space)) begin
				scan_phase = PH_DONE;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_limit = LIMIT_RESET;
			clear_line();
			expected_records.delete();
			mismatches = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				length_limit = cfg_wr_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				take_text_byte(s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_records.size() == 0) begin
					report($sformatf("record beat with none pending, tdata %0h", m_axis_tdata));
				end else begin
					want = expected_records.pop_front();
					if (m_axis_tuser[0] !== want.accepted) begin
						report($sformatf("accepted %0b, expected %0b",
							m_axis_tuser[0], want.accepted));
					end
					if (m_axis_tdata[31:0] !== want.start_pos) begin
						report($sformatf("start_position %0h, expected %0h",
							m_axis_tdata[31:0], want.start_pos));
					end
					if (m_axis_tdata[63:32] !== want.end_pos) begin
						report($sformatf("end_position %0h, expected %0h",
							m_axis_tdata[63:32], want.end_pos));
					end
					if (m_axis_tdata[71:64] !== want.name_len) begin
						report($sformatf("name_length %0d, expected %0d",
							m_axis_tdata[71:64], want.name_len));
					end
				end
			end
			fail_count  <= mismatches;
			outstanding <= expected_records.size();
		end
	end

endmodule

// ----- sim/bed_line_record_parser_test.sv -----
`timescale 1ns / 100ps
// top of the line parser bench: clock, reset, byte stimulus, limit writes and verdict
// depends on blrp_pkg, bed_line_record_parser and bed_line_record_checker
module bed_line_record_parser_test;
	import blrp_pkg::*;

	// cycles without any beat on either channel before the run is given up
	localparam int WATCHDOG_LIMIT = 1000;
	// random byte budget per limit setting, six settings in all
	localparam int PHASE_BEATS = 70;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] text_byte
	logic        s_axis_tlast;   // line_end
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;   // [31:0] start_position, [63:32] end_position,
	                             // [71:64] name_length
	logic [0:0]  m_axis_tuser;   // [0] accepted
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;

	int fail_count;
	int outstanding;
	int quiet_cycles;
	int beats_sent;
	bit drain_phase;           // final stretch: no idling on either side
	logic [7:0] line_buf[$];   // bytes of the line being built

	bed_line_record_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	bed_line_record_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	always #2 clk = ~clk;

	// any byte except tab and the zero terminator
	function automatic logic [7:0] text_noise();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(1, 255));
		end while (b == CH_TAB);
		return b;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_buf.push_back(s[i]);
		end
	endtask

	// one byte beat; holds tvalid until the parser takes it, then maybe idles
	task automatic send_beat(input logic [7:0] b, input logic last);
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		s_axis_tvalid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		beats_sent++;
		if (!drain_phase && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// send the built line, ended by a zero byte or by a tlast beat with a don't-care byte
	task automatic finish_line(input bit zero_term);
		foreach (line_buf[i]) begin
			send_beat(line_buf[i], 1'b0);
		end
		if (zero_term) begin
			send_beat(CH_NUL, 1'b0);
		end else begin
			send_beat(8'($urandom_range(0, 255)), 1'b1);
		end
		line_buf.delete();
	endtask

	task automatic send_text(input string s, input bit zero_term);
		line_buf.delete();
		add_text(s);
		finish_line(zero_term);
	endtask

	// stop sending until every pending record has come out, then let the pipe drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] value);
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// numeric field: optional white space, sign, digits and trailing junk
	task automatic add_number();
		int      n;
		int      k;
		longint  v;
		n = $urandom_range(0, 2);
		repeat (n) begin
			k = $urandom_range(0, 4);
			line_buf.push_back((k == 4) ? CH_SPACE : 8'(8'h0A + k));
		end
		k = $urandom_range(0, 3);
		if (k == 1) begin
			line_buf.push_back(CH_PLUS);
		end else if (k == 2) begin
			line_buf.push_back(CH_MINUS);
		end
		// white space after the sign ends the number
		if ($urandom_range(0, 15) == 0) begin
			line_buf.push_back(CH_SPACE);
		end
		k = $urandom_range(0, 9);
		if (k == 1 || k == 2) begin
			// around the 32-bit signed limit
			v = 64'd2147483646 + $urandom_range(0, 3);
			add_text($sformatf("%0d", v));
		end else if (k != 0) begin
			n = (k == 3) ? $urandom_range(11, 20) : $urandom_range(1, 10);
			repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		end
		if ($urandom_range(0, 5) == 0) begin
			line_buf.push_back(text_noise());
		end
	endtask

	// mostly well-formed records with random content, some noise lines
	task automatic build_line(input bit long_names);
		int n;
		int r;
		int extra;
		line_buf.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 12);
			repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 5) == 0) begin
			n = $urandom_range(0, 6);
			repeat (n) line_buf.push_back(text_noise());
		end else begin
			add_text("chr");
			if (long_names && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(240, 300);
			end else begin
				n = $urandom_range(0, 8);
			end
			repeat (n) line_buf.push_back(text_noise());
			// spoil one prefix byte now and then
			if ($urandom_range(0, 7) == 0) begin
				line_buf[$urandom_range(0, 2)] = text_noise();
			end
		end
		r = $urandom_range(0, 9);
		if (r < 2) begin
			extra = r;
		end else if (r < 8) begin
			extra = 2;
		end else begin
			extra = $urandom_range(3, 5);
		end
		for (int i = 0; i < extra; i++) begin
			line_buf.push_back(CH_TAB);
			if (i < 2) begin
				add_number();
			end else begin
				n = $urandom_range(0, 4);
				repeat (n) line_buf.push_back(text_noise());
			end
		end
	endtask

	// receiver: ready runs and stall bursts, always ready in the final stretch
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			if (drain_phase) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("bed_line_record_parser_test NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [7:0] limits[6];
		int         phase_start;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		s_axis_tlast  = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 8'd0;
		drain_phase   = 1'b0;
		beats_sent    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines under the reset limit of 40
		send_text("chr1\t100\t200", 1'b0);
		send_text("chrX\t-5\t+7\textra\tmore", 1'b0);           // fields past the third
		send_text("chr2\t\01312\t\015\012 99999999999", 1'b1);  // white space, overflow
		send_text("chr3\t-99999999999\t-3", 1'b0);              // negative overflow
		send_text("chr4\t  \t-", 1'b0);                         // empty field, bare sign
		send_text("chr5\t+ 5\t5x9", 1'b0);                      // space after sign, junk
		send_text("ch\t1\t2", 1'b0);                            // name too short
		send_text("chrA\t1", 1'b1);                             // end field missing
		send_text("chrB", 1'b0);
		send_text("", 1'b0);
		send_text("xhr1\t1\t2", 1'b0);                          // prefix mismatches
		send_text("cxr1\t1\t2", 1'b0);
		send_text("chx1\t1\t2", 1'b0);
		send_text("chr6\t0\t0", 1'b0);                          // end of zero
		send_text("chr7\t-2147483648\t2147483648", 1'b0);
		// high bytes in the name and a zero terminator
		add_text("chr");
		line_buf.push_back(8'hFF);
		line_buf.push_back(8'h80);
		add_text("\t1\t2");
		finish_line(1'b1);
		// names of 39 and 40 bytes straddle the limit
		add_text("chr");
		repeat (36) line_buf.push_back("a");
		add_text("\t1\t9");
		finish_line(1'b0);
		add_text("chr");
		repeat (37) line_buf.push_back("a");
		add_text("\t1\t9");
		finish_line(1'b0);

		// limits of zero and one reject every line
		settle();
		write_limit(8'd0);
		send_text("chr1\t1\t2", 1'b0);
		settle();
		write_limit(8'd1);
		send_text("chr1\t1\t2", 1'b0);

		// random lines under a range of limits, the widest one with long names
		limits[0] = 8'($urandom_range(1, 255));
		limits[1] = NAME_MAX;
		limits[2] = 8'd3;
		limits[3] = 8'd4;
		limits[4] = 8'($urandom_range(2, 60));
		limits[5] = LIMIT_RESET;
		for (int p = 0; p < 6; p++) begin
			settle();
			write_limit(limits[p]);
			drain_phase = (p == 5);
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				build_line(p == 1);
				finish_line($urandom_range(0, 5) == 0);
				// now and then the sender holds off until every record is out
				if ($urandom_range(0, 14) == 0) begin
					settle();
				end
			end
		end

		settle();
		if (fail_count == 0) begin
			$display("bed_line_record_parser_test OK");
		end else begin
			$display("bed_line_record_parser_test NOT OK");
		end
		$finish;
	end

endmodule
